### rtl/cla_pkg.sv
`timescale 1ns / 1ps
package cla_pkg;

  localparam int LINE_MAX_DEFAULT = 32767;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [14:0] SLASH_MAX = 15'd32767;
  localparam logic [14:0] ARGS_MAX  = 15'd32765;

  // out_kind codes
  localparam logic [1:0] KIND_RUN      = 2'd0;
  localparam logic [1:0] KIND_END_ARG  = 2'd1;
  localparam logic [1:0] KIND_END_LINE = 2'd2;

  typedef enum logic [1:0] {
    PH_PROG = 2'd0,
    PH_SKIP = 2'd1,
    PH_ARG  = 2'd2
  } phase_t;

  // one result slot of a byte's bundle
  typedef enum logic [1:0] {
    SLOT_SLASH    = 2'd0,
    SLOT_CHAR     = 2'd1,
    SLOT_END_ARG  = 2'd2,
    SLOT_END_LINE = 2'd3
  } slot_t;

  // everything one byte produces, in emit order
  typedef struct packed {
    logic [1:0]       cnt;
    slot_t [2:0]      slot;
    logic [14:0]      slash_amt;
    logic [7:0]       ch;
    logic [14:0]      argc;
    logic [15:0]      cc;
  } bundle_t;

endpackage

### rtl/command_line_argument_splitter.sv
`timescale 1ns / 1ps
// Command line splitter. Bytes of a command line enter on the s_ group, one
// item per byte; a zero byte ends the line. Results leave on the m_ group:
// tuser is the kind (character run, end of argument, end of line), tlast
// marks the last result caused by one input byte.
// The front classifies each byte against the parse state and writes a
// bundle of up to three results into a two-entry queue; the back walks the
// bundle one result per cycle while the receiver is ready.
// A byte's bundle is registered in the queue before its first result is
// offered. Throughput: one byte per cycle while each byte gives at most one
// result and the receiver is ready; bytes giving more results let the queue
// fill, and s_tready drops while it is full. Bytes that give no result
// (backslashes, quote toggles, blanks between arguments) never enter the queue.
// Reset clears the parse state and empties the queue; the next byte starts a
// program name. When the receiver stalls, the queue fills and s_tready
// drops after two pending bytes; nothing is lost.
module command_line_argument_splitter #(
  parameter int LINE_MAX = cla_pkg::LINE_MAX_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] out_char, [22:8] repeat_count, [37:23] arg_count, [53:38] char_count
  output logic [55:0] m_tdata,
  output logic [1:0]  m_tuser,   // [1:0] out_kind
  output logic        m_tlast    // run_last
);
  import cla_pkg::*;

  bundle_t bundle, head;
  logic    take, push, pop, full, empty;

  assign s_tready = !full;
  assign take     = s_tvalid && s_tready;
  // bytes without results never enter the queue
  assign push     = take && (bundle.cnt != 2'd0);

  cla_front #(
    .LINE_MAX(LINE_MAX)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .char_in (s_tdata),
    .bundle  (bundle)
  );

  cla_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (bundle),
    .pop   (pop),
    .dout  (head),
    .full  (full),
    .empty (empty)
  );

  cla_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

### rtl/cla_front.sv
`timescale 1ns / 1ps
module cla_front #(
  parameter int LINE_MAX = cla_pkg::LINE_MAX_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       char_in,
  output cla_pkg::bundle_t bundle
);
  import cla_pkg::*;

  localparam logic [16:0] Lim = 17'(LINE_MAX);

  phase_t      phase, phase_next;
  logic        in_quotes, in_quotes_next;
  logic        quote_pending, quote_pending_next;
  logic [14:0] slash_run, slash_run_next;
  logic [14:0] arg_counter, arg_counter_next;
  logic [15:0] char_counter, char_counter_next;

  logic        em_sl, em_ch, em_ea, em_el, clear, run_arg, q_t, blank;
  logic        eff_q, eff_qp;
  logic [14:0] eff_sl, sl_amt;
  logic [7:0]  ch;
  logic [16:0] sum1, sum2;
  logic [15:0] cc1, cc2;
  logic [1:0]  idx;

  assign blank = (char_in == CH_SPACE) || (char_in == CH_TAB);

  always_comb begin
    phase_next         = phase;
    in_quotes_next     = in_quotes;
    quote_pending_next = quote_pending;
    slash_run_next     = slash_run;
    arg_counter_next   = arg_counter;
    em_sl   = 1'b0;
    em_ch   = 1'b0;
    em_ea   = 1'b0;
    em_el   = 1'b0;
    clear   = 1'b0;
    run_arg = 1'b0;
    sl_amt  = '0;
    ch      = char_in;
    eff_q   = in_quotes;
    eff_qp  = quote_pending;
    eff_sl  = slash_run;
    q_t     = in_quotes;
    unique case (phase)
      PH_SKIP: begin
        if (char_in == CH_NUL) begin
          em_el = 1'b1;
          clear = 1'b1;
        end else if (!blank) begin
          // first byte of a new argument
          run_arg    = 1'b1;
          phase_next = PH_ARG;
          eff_q      = 1'b0;
          eff_qp     = 1'b0;
          eff_sl     = '0;
          if (arg_counter < ARGS_MAX) begin
            arg_counter_next = arg_counter + 15'd1;
          end
        end
      end
      PH_ARG: begin
        run_arg = 1'b1;
      end
      default: begin
        // program name: quotes toggle, blank outside quotes ends it
        if (char_in == CH_QUOTE) begin
          in_quotes_next = !in_quotes;
        end else if (char_in == CH_NUL) begin
          em_ea = 1'b1;
          em_el = 1'b1;
          clear = 1'b1;
        end else if (!in_quotes && blank) begin
          em_ea          = 1'b1;
          in_quotes_next = 1'b0;
          phase_next     = PH_SKIP;
        end else begin
          em_ch = 1'b1;
        end
      end
    endcase

    if (run_arg) begin
      if (eff_qp && char_in == CH_QUOTE) begin
        // doubled quote inside quotes
        em_ch              = 1'b1;
        ch                 = CH_QUOTE;
        quote_pending_next = 1'b0;
        in_quotes_next     = eff_q;
        slash_run_next     = eff_sl;
      end else begin
        q_t = eff_qp ? 1'b0 : eff_q;
        quote_pending_next = 1'b0;
        in_quotes_next     = q_t;
        slash_run_next     = eff_sl;
        if (char_in == CH_BSLASH) begin
          if (eff_sl != SLASH_MAX) begin
            slash_run_next = eff_sl + 15'd1;
          end
        end else if (char_in == CH_QUOTE) begin
          sl_amt         = eff_sl >> 1;
          em_sl          = |sl_amt;
          slash_run_next = '0;
          if (eff_sl[0]) begin
            em_ch = 1'b1;
            ch    = CH_QUOTE;
          end else if (q_t) begin
            quote_pending_next = 1'b1;
          end else begin
            in_quotes_next = 1'b1;
          end
        end else begin
          sl_amt         = eff_sl;
          em_sl          = |eff_sl;
          slash_run_next = '0;
          if (char_in == CH_NUL) begin
            em_ea = 1'b1;
            em_el = 1'b1;
            clear = 1'b1;
          end else if (!q_t && blank) begin
            em_ea      = 1'b1;
            phase_next = PH_SKIP;
          end else begin
            em_ch = 1'b1;
          end
        end
      end
    end

    if (clear) begin
      phase_next         = PH_PROG;
      in_quotes_next     = 1'b0;
      quote_pending_next = 1'b0;
      slash_run_next     = '0;
      arg_counter_next   = '0;
    end
  end

  // saturating byte count: slash run first, then a single byte or terminator
  always_comb begin
    sum1 = {1'b0, char_counter} + (em_sl ? {2'b00, sl_amt} : 17'd0);
    cc1  = (sum1 >= Lim) ? Lim[15:0] : sum1[15:0];
    sum2 = {1'b0, cc1} + {16'd0, (em_ch | em_ea)};
    cc2  = (sum2 >= Lim) ? Lim[15:0] : sum2[15:0];
    char_counter_next = clear ? 16'd0 : cc2;
  end

  always_comb begin
    bundle.slot      = {SLOT_SLASH, SLOT_SLASH, SLOT_SLASH};
    bundle.slash_amt = sl_amt;
    bundle.ch        = ch;
    bundle.argc      = arg_counter + 15'd2;
    bundle.cc        = cc2;
    idx = 2'd0;
    if (em_sl) begin
      bundle.slot[idx] = SLOT_SLASH;
      idx = idx + 2'd1;
    end
    if (em_ch) begin
      bundle.slot[idx] = SLOT_CHAR;
      idx = idx + 2'd1;
    end
    if (em_ea) begin
      bundle.slot[idx] = SLOT_END_ARG;
      idx = idx + 2'd1;
    end
    if (em_el) begin
      bundle.slot[idx] = SLOT_END_LINE;
      idx = idx + 2'd1;
    end
    bundle.cnt = idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_PROG;
      in_quotes     <= 1'b0;
      quote_pending <= 1'b0;
      slash_run     <= '0;
      arg_counter   <= '0;
      char_counter  <= '0;
    end else if (take) begin
      phase         <= phase_next;
      in_quotes     <= in_quotes_next;
      quote_pending <= quote_pending_next;
      slash_run     <= slash_run_next;
      arg_counter   <= arg_counter_next;
      char_counter  <= char_counter_next;
    end
  end

endmodule

### rtl/cla_queue.sv
`timescale 1ns / 1ps
module cla_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cla_pkg::bundle_t din,
  input  logic             pop,
  output cla_pkg::bundle_t dout,
  output logic             full,
  output logic             empty
);
  import cla_pkg::*;

  bundle_t    mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### rtl/cla_back.sv
`timescale 1ns / 1ps
module cla_back (
  input  logic             clk,
  input  logic             rst,
  input  cla_pkg::bundle_t head,
  input  logic             empty,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [55:0]      m_tdata,
  output logic [1:0]       m_tuser,
  output logic             m_tlast
);
  import cla_pkg::*;

  logic [1:0]  idx;
  slot_t       slot;
  logic [7:0]  out_char;
  logic [14:0] rep, argc;
  logic [15:0] cc;

  assign m_tvalid = !empty;
  assign slot     = head.slot[idx];
  assign m_tlast  = (idx == head.cnt - 2'd1);
  assign pop      = m_tvalid && m_tready && m_tlast;

  always_comb begin
    m_tuser  = KIND_RUN;
    out_char = '0;
    rep      = '0;
    argc     = '0;
    cc       = '0;
    unique case (slot)
      SLOT_SLASH: begin
        out_char = CH_BSLASH;
        rep      = head.slash_amt;
      end
      SLOT_CHAR: begin
        out_char = head.ch;
        rep      = 15'd1;
      end
      SLOT_END_ARG: begin
        m_tuser = KIND_END_ARG;
      end
      SLOT_END_LINE: begin
        m_tuser = KIND_END_LINE;
        argc    = head.argc;
        cc      = head.cc;
      end
    endcase
  end

  assign m_tdata = {2'b00, cc, argc, rep, out_char};

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (m_tvalid && m_tready) begin
      idx <= m_tlast ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

### dv/split_checker.sv
`timescale 1ns / 1ps
// Watches both item channels of the splitter, predicts the results of every
// accepted byte and compares them in order with what the block hands out.
module split_checker #(
  parameter int LINE_MAX = cla_pkg::LINE_MAX_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending
);
  import cla_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  ch;
    logic [14:0] rep;
    logic        last;
    logic [14:0] argc;
    logic [15:0] cc;
  } piece_t;

  // parse state
  phase_t      phase;
  logic        in_quotes;
  logic        quote_open;   // even-slash quote inside quotes, waiting on next byte
  logic [14:0] slashes;
  logic [14:0] args;
  logic [15:0] chars;

  piece_t byte_pieces[3];
  int     byte_n;
  piece_t predicted_pieces[$];
  int     errors = 0;
  int     n_pending = 0;

  assign fail_count = errors;
  assign pending    = n_pending;

  function automatic void clear_parse();
    phase      = PH_PROG;
    in_quotes  = 1'b0;
    quote_open = 1'b0;
    slashes    = '0;
    args       = '0;
    chars      = '0;
  endfunction

  function automatic void count_chars(int n);
    int lim;
    int c;
    lim = (LINE_MAX > 65535) ? 65535 : LINE_MAX;
    c   = int'(chars);
    if (c >= lim || n >= lim - c) chars = lim[15:0];
    else chars = 16'(c + n);
  endfunction

  function automatic void put(logic [1:0] kind, logic [7:0] c, int n);
    piece_t p;
    if (byte_n >= 3) return;
    p = '0;
    p.kind = kind;
    if (kind == KIND_RUN) begin
      p.ch  = c;
      p.rep = n[14:0];
      count_chars(n);
    end else if (kind == KIND_END_ARG) begin
      count_chars(1);
    end else begin
      p.argc = args + 15'd2;
      p.cc   = chars;
    end
    byte_pieces[byte_n] = p;
    byte_n++;
  endfunction

  function automatic void close_line();
    put(KIND_END_LINE, 8'h00, 0);
    clear_parse();
  endfunction

  function automatic void flush_slashes(int n);
    if (n > 0) put(KIND_RUN, CH_BSLASH, n);
  endfunction

  function automatic logic blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  // byte inside a later argument: backslash and quote rules
  function automatic void arg_char(logic [7:0] c);
    logic odd;
    if (quote_open) begin
      quote_open = 1'b0;
      if (c == CH_QUOTE) begin
        put(KIND_RUN, CH_QUOTE, 1);
        return;
      end
      in_quotes = 1'b0;
    end
    if (c == CH_BSLASH) begin
      if (slashes < SLASH_MAX) slashes++;
      return;
    end
    if (c == CH_QUOTE) begin
      odd = slashes[0];
      flush_slashes(int'(slashes >> 1));
      slashes = '0;
      if (odd) put(KIND_RUN, CH_QUOTE, 1);
      else if (in_quotes) quote_open = 1'b1;
      else in_quotes = 1'b1;
      return;
    end
    flush_slashes(int'(slashes));
    slashes = '0;
    if (c == CH_NUL) begin
      put(KIND_END_ARG, 8'h00, 0);
      close_line();
    end else if (!in_quotes && blank(c)) begin
      put(KIND_END_ARG, 8'h00, 0);
      phase = PH_SKIP;
    end else begin
      put(KIND_RUN, c, 1);
    end
  endfunction

  function automatic void split_byte(logic [7:0] c);
    byte_n = 0;
    case (phase)
      PH_SKIP: begin
        if (c == CH_NUL) begin
          close_line();
        end else if (!blank(c)) begin
          if (args < ARGS_MAX) args++;
          phase      = PH_ARG;
          in_quotes  = 1'b0;
          quote_open = 1'b0;
          slashes    = '0;
          arg_char(c);
        end
      end
      PH_ARG: arg_char(c);
      default: begin
        // program name: quotes toggle, no backslash rules
        if (c == CH_QUOTE) begin
          in_quotes = !in_quotes;
        end else if (c == CH_NUL) begin
          put(KIND_END_ARG, 8'h00, 0);
          close_line();
        end else if (!in_quotes && blank(c)) begin
          put(KIND_END_ARG, 8'h00, 0);
          in_quotes = 1'b0;
          phase     = PH_SKIP;
        end else begin
          put(KIND_RUN, c, 1);
        end
      end
    endcase
    if (byte_n > 0) byte_pieces[byte_n - 1].last = 1'b1;
    for (int i = 0; i < byte_n; i++) predicted_pieces.push_back(byte_pieces[i]);
  endfunction

  function automatic void check_piece(piece_t got);
    piece_t want;
    if (predicted_pieces.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t split_checker: unexpected result kind=%0d ch=%02h rep=%0d",
                 $realtime, got.kind, got.ch, got.rep,
                 " last=%0b argc=%0d cc=%0d", got.last, got.argc, got.cc);
      return;
    end
    want = predicted_pieces.pop_front();
    if (got !== want) begin
      errors++;
      if (errors <= 10) begin
        $display("%0t split_checker: mismatch", $realtime);
        $display("  expected kind=%0d ch=%02h rep=%0d last=%0b argc=%0d cc=%0d",
                 want.kind, want.ch, want.rep, want.last, want.argc, want.cc);
        $display("  actual   kind=%0d ch=%02h rep=%0d last=%0b argc=%0d cc=%0d",
                 got.kind, got.ch, got.rep, got.last, got.argc, got.cc);
      end
    end
  endfunction

  // results first: a result can never belong to the byte taken at the same edge
  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      predicted_pieces.delete();
    end else begin
      if (m_tvalid && m_tready)
        check_piece('{kind: m_tuser, ch: m_tdata[7:0], rep: m_tdata[22:8], last: m_tlast,
                      argc: m_tdata[37:23], cc: m_tdata[53:38]});
      if (s_tvalid && s_tready) split_byte(s_tdata);
    end
    n_pending <= predicted_pieces.size();
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Top of the splitter bench: clock, reset, byte stimulus and result-side
// backpressure. All prediction and comparison lives in split_checker.
module tb;
  import cla_pkg::*;

  localparam int LINE_MAX   = LINE_MAX_DEFAULT;
  localparam int RAND_ITEMS = 390;
  localparam int CALM_ITEMS = 60;    // closing random bytes sent with no idling
  localparam int QUIET_MAX  = 1000;  // cycles without any handshake before giving up
  localparam int TAIL       = 20;    // settle cycles after the last result

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;       // [7:0] char_in
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [7:0] out_char, [22:8] repeat_count, [37:23] arg_count, [53:38] char_count
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;               // [1:0] out_kind
  logic        m_tlast;               // run_last

  int fail_count;
  int pending;

  bit jitter_on = 1'b0;   // random idle bursts on both sides
  int chars_sent = 0;
  int stall_left = 0;
  int quiet = 0;

  always #5 clk = ~clk;

  command_line_argument_splitter #(.LINE_MAX(LINE_MAX)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  split_checker #(.LINE_MAX(LINE_MAX)) chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver: drops ready in stall bursts of random length while jitter is on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (jitter_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 7) - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog: only cycles with no handshake on either side count.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_MAX) begin
        $display("tb: FAIL");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // One byte onto the input channel; valid stays up after the handshake so
  // back-to-back bytes follow without a gap.
  task automatic push_char(input logic [7:0] b);
    int gap;
    if (jitter_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    chars_sent++;
  endtask

  // Drop valid and wait for every predicted result to come out. The first
  // edge lets the checker's count catch up with the last accepted byte.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Half of the bytes are parser-relevant: blanks, quotes, backslashes; the rest
  // printable text, control codes and high bytes.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 14) return r[0] ? CH_SPACE : CH_TAB;
    if (r < 32) return CH_QUOTE;
    if (r < 50) return CH_BSLASH;
    if (r < 56) return 8'($urandom_range(8'h80, 8'hff));
    if (r < 58) return 8'($urandom_range(8'h01, 8'h1f));
    return 8'($urandom_range(8'h21, 8'h7e));
  endfunction

  // A line ends with a zero byte. About one line in eight is raw noise,
  // where a stray zero just ends the line early.
  task automatic push_random_line();
    int len;
    len = $urandom_range(1, 24);
    if ($urandom_range(0, 7) == 0) begin
      repeat (len) push_char(8'($urandom_range(0, 255)));
    end else begin
      repeat (len) push_char(pick_char());
    end
    push_char(CH_NUL);
  endtask

  // Hand-picked lines, each aimed at a parsing rule.
  logic [7:0] directed_chars[] = '{
    // quoted program name holding a blank, closed by a tab
    CH_QUOTE, "a", CH_SPACE, CH_QUOTE, CH_TAB,
    // extra blank, then two backslashes and a quote: one slash, quotes open
    CH_SPACE, CH_BSLASH, CH_BSLASH, CH_QUOTE, "x",
    // doubled quote inside quotes gives a literal quote
    CH_QUOTE, CH_QUOTE,
    // lone quote inside quotes, then a plain byte closes the quotes
    CH_QUOTE, "y",
    // three backslashes and a quote: one slash and a literal quote
    CH_BSLASH, CH_BSLASH, CH_BSLASH, CH_QUOTE,
    // top byte, trailing backslash flushed by the line end
    8'hff, CH_BSLASH, CH_NUL,
    // empty line right after end of line
    CH_NUL,
    // blank program name, blank in skip phase, end in skip phase
    CH_SPACE, CH_TAB, CH_NUL,
    // pending quote inside quotes, then the line end
    "p", CH_SPACE, CH_QUOTE, "k", CH_QUOTE, CH_NUL
  };

  initial begin
    int rand_start;
    bit drained;
    drained = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_chars[i]) push_char(directed_chars[i]);

    // Random lines, jitter switched on and off per line; the closing
    // stretch runs with no idling on either side.
    rand_start = chars_sent;
    while (chars_sent - rand_start < RAND_ITEMS) begin
      jitter_on = (chars_sent - rand_start < RAND_ITEMS - CALM_ITEMS) &&
                  ($urandom_range(0, 3) != 0);
      push_random_line();
      if (!drained && chars_sent - rand_start > RAND_ITEMS / 2) begin
        drain();
        drained = 1'b1;
      end
    end
    jitter_on = 1'b0;

    drain();
    repeat (TAIL) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
